>>> rtl/lpc_pkg.sv
package lpc_pkg;

  localparam int unsigned SLOTS_DEFAULT = 16;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned PID_W   = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned HELD_W  = 5;
  localparam int unsigned CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [REQ_W-1:0] REQ_GET   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NEW   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MARK  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd3;

  localparam logic [CMD_W-1:0] CMD_ACK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FETCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WB    = 2'd2;

endpackage

>>> rtl/lpc_cfg_if.sv
interface lpc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lpc_pkg::CAP_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lpc_req_if.sv
interface lpc_req_if;
  logic                        valid;
  logic                        ready;
  logic [lpc_pkg::REQ_W-1:0]   req_type;
  logic [lpc_pkg::PID_W-1:0]   page_id;

  modport source (output valid, output req_type, output page_id, input ready);
  modport sink   (input valid, input req_type, input page_id, output ready);
endinterface

>>> rtl/lpc_rsp_if.sv
interface lpc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lpc_pkg::CMD_W-1:0]   cmd;
  logic [lpc_pkg::PID_W-1:0]   cmd_page_id;
  logic [lpc_pkg::SLOT_W-1:0]  slot;
  logic                        hit;
  logic [lpc_pkg::CNT_W-1:0]   hit_count;
  logic [lpc_pkg::CNT_W-1:0]   miss_count;
  logic [lpc_pkg::HELD_W-1:0]  held_count;
  logic                        last;

  modport source (output valid, output cmd, output cmd_page_id, output slot, output hit,
                  output hit_count, output miss_count, output held_count, output last,
                  input ready);
  modport sink   (input valid, input cmd, input cmd_page_id, input slot, input hit,
                  input hit_count, input miss_count, input held_count, input last,
                  output ready);
endinterface

>>> rtl/lru_page_cache_controller.sv
// Fully associative page-tag cache with LRU replacement and dirty marks.
// req_i takes one request (get, new, mark dirty, flush) when valid and ready
// are high; ready is high only while the controller is idle. rsp_o delivers
// one or more result items per request (fetch, write-back or acknowledge),
// the final one flagged by last. cfg_i writes the capacity register; it is
// always ready and should be written only while idle.
// Get, new and mark requests scan the tag memory one slot per cycle, then
// decide, write back a dirty victim first if one is evicted, and load the
// final result. A request is taken only while idle, so a new one waits until
// the final item of the last one is loaded. A flush walks the slots one per
// cycle up to the highest dirty one, pausing on each dirty slot to load its
// write-back item, which the receiver can stall; when nothing is dirty it
// answers with a single acknowledge. The tag memory is read through one
// registered read port, one slot at a time.
// Results sit in an output register; while the receiver stalls, the
// controller holds that item and waits before loading the next one. A new
// request is taken as soon as the final item is loaded, even while it waits.
// Reset empties the cache, clears the hit and miss counters and sets the
// capacity to 16; tag memory contents are don't-care until written.
module lru_page_cache_controller #(
  parameter int unsigned SLOTS = lpc_pkg::SLOTS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpc_cfg_if.sink   cfg_i,
  lpc_req_if.sink   req_i,
  lpc_rsp_if.source rsp_o
);
  import lpc_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned OW = $clog2(SLOTS + 1);
  localparam int unsigned EW = (OW > CAP_W) ? OW : CAP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [IW-1:0] AGE_MAX  = IW'(SLOTS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_WB     = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;
  localparam logic [2:0] ST_FLUSH  = 3'd6;
  localparam logic [2:0] ST_FWB    = 3'd7;

  logic [2:0]       state_q;
  logic [CAP_W-1:0] cap_q;
  logic [REQ_W-1:0] req_q;
  logic [PID_W-1:0] pid_q;
  logic [IW-1:0]    idx_q;
  logic             cmp_en_q;
  logic [IW-1:0]    cmp_idx_q;

  logic             valid_q [SLOTS];
  logic             dirty_q [SLOTS];
  logic [IW-1:0]    age_q   [SLOTS];

  logic [CNT_W-1:0] hits_q;
  logic [CNT_W-1:0] misses_q;
  logic [OW-1:0]    occ_q;

  logic             match_found_q;
  logic [IW-1:0]    match_idx_q;
  logic             vic_found_q;
  logic [IW-1:0]    vic_idx_q;
  logic [IW-1:0]    vic_age_q;
  logic [PID_W-1:0] vic_tag_q;
  logic             free_found_q;
  logic [IW-1:0]    free_idx_q;

  logic [CMD_W-1:0] fin_cmd_q;
  logic [PID_W-1:0] fin_pid_q;
  logic [IW-1:0]    fin_slot_q;
  logic             fin_hit_q;

  logic [PID_W-1:0] tag_mem [SLOTS];
  logic [PID_W-1:0] rdata_q;

  logic              out_valid_q;
  logic [CMD_W-1:0]  out_cmd_q;
  logic [PID_W-1:0]  out_pid_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_hit_q;
  logic [CNT_W-1:0]  out_hits_q;
  logic [CNT_W-1:0]  out_misses_q;
  logic [HELD_W-1:0] out_held_q;
  logic              out_last_q;

  function automatic logic [SLOT_W-1:0] slot_field(input logic [IW-1:0] idx);
    logic [IW+SLOT_W-1:0] t;
    t = {{SLOT_W{1'b0}}, idx};
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [HELD_W-1:0] held_field(input logic [OW-1:0] occ);
    logic [OW+HELD_W-1:0] t;
    t = {{HELD_W{1'b0}}, occ};
    return t[HELD_W-1:0];
  endfunction

  // Decision logic, evaluated from the scan results
  logic          any_dirty;
  logic          out_free;
  logic [EW-1:0] cap_ext;
  logic [EW-1:0] cap_eff;
  logic          full;
  logic          is_ins;
  logic          do_evict;
  logic          placed_new;
  logic [IW-1:0] place_idx;
  logic          need_wb;
  logic          cmp_v;

  always_comb begin
    any_dirty = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      any_dirty = any_dirty | (valid_q[i] & dirty_q[i]);
    end
  end

  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    cap_ext = EW'(cap_q);
    if (cap_q == '0) begin
      cap_eff = EW'(1);
    end else if (cap_ext > EW'(SLOTS)) begin
      cap_eff = EW'(SLOTS);
    end else begin
      cap_eff = cap_ext;
    end
    full       = EW'(occ_q) >= cap_eff;
    is_ins     = ((req_q == REQ_GET) || (req_q == REQ_NEW)) && !match_found_q;
    do_evict   = is_ins && full && vic_found_q;
    placed_new = free_found_q || do_evict;
    // Lowest free slot once the victim has gone
    if (do_evict && (!free_found_q || (vic_idx_q < free_idx_q))) begin
      place_idx = vic_idx_q;
    end else if (free_found_q) begin
      place_idx = free_idx_q;
    end else begin
      place_idx = '0;
    end
    need_wb = do_evict && dirty_q[vic_idx_q];
    cmp_v   = valid_q[cmp_idx_q];
  end

  // Tag memory: one write in the decide step, one registered read a cycle while scanning or flushing
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECIDE && is_ins) begin
      tag_mem[place_idx] <= pid_q;
    end
    if (state_q == ST_SCAN || state_q == ST_FLUSH) begin
      rdata_q <= tag_mem[idx_q];
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cap_q         <= CAP_RESET;
      req_q         <= REQ_GET;
      pid_q         <= '0;
      idx_q         <= '0;
      cmp_en_q      <= 1'b0;
      cmp_idx_q     <= '0;
      hits_q        <= '0;
      misses_q      <= '0;
      occ_q         <= '0;
      match_found_q <= 1'b0;
      match_idx_q   <= '0;
      vic_found_q   <= 1'b0;
      vic_idx_q     <= '0;
      vic_age_q     <= '0;
      vic_tag_q     <= '0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      fin_cmd_q     <= CMD_ACK;
      fin_pid_q     <= '0;
      fin_slot_q    <= '0;
      fin_hit_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_cmd_q     <= CMD_ACK;
      out_pid_q     <= '0;
      out_slot_q    <= '0;
      out_hit_q     <= 1'b0;
      out_hits_q    <= '0;
      out_misses_q  <= '0;
      out_held_q    <= '0;
      out_last_q    <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        valid_q[i] <= 1'b0;
        dirty_q[i] <= 1'b0;
        age_q[i]   <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        cap_q <= cfg_i.data;
      end

      if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      cmp_en_q <= (state_q == ST_SCAN);

      // Compare stage: one tag per cycle vs the request; also finds the oldest and first free slot
      if (cmp_en_q) begin
        if (cmp_v && (rdata_q == pid_q) && !match_found_q) begin
          match_found_q <= 1'b1;
          match_idx_q   <= cmp_idx_q;
        end
        if (cmp_v && (!vic_found_q || (age_q[cmp_idx_q] > vic_age_q))) begin
          vic_found_q <= 1'b1;
          vic_idx_q   <= cmp_idx_q;
          vic_age_q   <= age_q[cmp_idx_q];
          vic_tag_q   <= rdata_q;
        end
        if (!cmp_v && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= cmp_idx_q;
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            req_q         <= req_i.req_type;
            pid_q         <= req_i.page_id;
            idx_q         <= '0;
            match_found_q <= 1'b0;
            vic_found_q   <= 1'b0;
            free_found_q  <= 1'b0;
            if (req_i.req_type == REQ_FLUSH) begin
              if (any_dirty) begin
                state_q <= ST_FLUSH;
              end else begin
                fin_cmd_q  <= CMD_ACK;
                fin_pid_q  <= '0;
                fin_slot_q <= '0;
                fin_hit_q  <= 1'b0;
                state_q    <= ST_FIN;
              end
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          cmp_idx_q <= idx_q;
          if (idx_q == LAST_IDX) begin
            state_q <= ST_DRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end

        ST_DRAIN: begin
          state_q <= ST_DECIDE;
        end

        ST_DECIDE: begin
          fin_pid_q <= pid_q;
          if (is_ins) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (IW'(i) == place_idx) begin
                valid_q[i] <= 1'b1;
                dirty_q[i] <= (req_q == REQ_NEW);
                age_q[i]   <= '0;
              end else if (do_evict && (IW'(i) == vic_idx_q)) begin
                valid_q[i] <= 1'b0;
                dirty_q[i] <= 1'b0;
                age_q[i]   <= '0;
              end else if (valid_q[i] && (age_q[i] < AGE_MAX)) begin
                age_q[i] <= age_q[i] + 1'b1;
              end
            end
            occ_q <= occ_q - OW'(do_evict) + OW'(placed_new);
          end else if (match_found_q && (req_q != REQ_MARK)) begin
            // Touch: younger slots age by one, the hit slot becomes newest
            for (int i = 0; i < SLOTS; i++) begin
              if (IW'(i) == match_idx_q) begin
                age_q[i] <= '0;
              end else if (valid_q[i] && (age_q[i] < age_q[match_idx_q])) begin
                age_q[i] <= age_q[i] + 1'b1;
              end
            end
          end
          if (match_found_q && ((req_q == REQ_NEW) || (req_q == REQ_MARK))) begin
            dirty_q[match_idx_q] <= 1'b1;
          end

          unique case (req_q)
            REQ_GET: begin
              if (match_found_q) begin
                if (hits_q != '1) hits_q <= hits_q + 1'b1;
                fin_cmd_q  <= CMD_ACK;
                fin_slot_q <= match_idx_q;
                fin_hit_q  <= 1'b1;
              end else begin
                if (misses_q != '1) misses_q <= misses_q + 1'b1;
                fin_cmd_q  <= CMD_FETCH;
                fin_slot_q <= place_idx;
                fin_hit_q  <= 1'b0;
              end
            end
            REQ_NEW: begin
              fin_cmd_q  <= CMD_ACK;
              fin_slot_q <= match_found_q ? match_idx_q : place_idx;
              fin_hit_q  <= match_found_q;
            end
            REQ_MARK: begin
              fin_cmd_q  <= CMD_ACK;
              fin_slot_q <= match_found_q ? match_idx_q : '0;
              fin_hit_q  <= match_found_q;
            end
            REQ_FLUSH: begin
              fin_cmd_q  <= CMD_ACK;
              fin_slot_q <= '0;
              fin_hit_q  <= 1'b0;
            end
            default: begin
              fin_cmd_q <= CMD_ACK;
            end
          endcase
          state_q <= need_wb ? ST_WB : ST_FIN;
        end

        ST_WB: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_cmd_q    <= CMD_WB;
            out_pid_q    <= vic_tag_q;
            out_slot_q   <= slot_field(vic_idx_q);
            out_hit_q    <= 1'b0;
            out_hits_q   <= hits_q;
            out_misses_q <= misses_q;
            out_held_q   <= held_field(occ_q);
            out_last_q   <= 1'b0;
            state_q      <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_cmd_q    <= fin_cmd_q;
            out_pid_q    <= fin_pid_q;
            out_slot_q   <= slot_field(fin_slot_q);
            out_hit_q    <= fin_hit_q;
            out_hits_q   <= hits_q;
            out_misses_q <= misses_q;
            out_held_q   <= held_field(occ_q);
            out_last_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end

        ST_FLUSH: begin
          // Stop on the next dirty slot; its tag is read this cycle
          if (valid_q[idx_q] && dirty_q[idx_q]) begin
            dirty_q[idx_q] <= 1'b0;
            state_q        <= ST_FWB;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end

        ST_FWB: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_cmd_q    <= CMD_WB;
            out_pid_q    <= rdata_q;
            out_slot_q   <= slot_field(idx_q);
            out_hit_q    <= 1'b0;
            out_hits_q   <= hits_q;
            out_misses_q <= misses_q;
            out_held_q   <= held_field(occ_q);
            // Lower slots are clean already, so any remaining dirty slot lies above
            out_last_q   <= !any_dirty;
            if (any_dirty) begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_FLUSH;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.cmd         = out_cmd_q;
  assign rsp_o.cmd_page_id = out_pid_q;
  assign rsp_o.slot        = out_slot_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.hit_count   = out_hits_q;
  assign rsp_o.miss_count  = out_misses_q;
  assign rsp_o.held_count  = out_held_q;
  assign rsp_o.last        = out_last_q;

  logic [SLOTS-1:0] valid_vec;
  logic [SLOTS-1:0] stray_dirty_vec;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      valid_vec[i]       = valid_q[i];
      stray_dirty_vec[i] = dirty_q[i] & ~valid_q[i];
    end
  end

  occ_matches_valid_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(occ_q))
    else $error("occupancy does not match the number of valid slots");

  no_dirty_invalid_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stray_dirty_vec == '0)
    else $error("dirty mark on an empty slot");

  hits_monotonic_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> hits_q >= $past(hits_q))
    else $error("hit counter decreased");

  busy_after_accept_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while a request was in flight");

endmodule
